// ===== design/nsfq_pkg.sv =====
// ----------------------------------------------------------------------------
// nsfq_pkg
// Shared constants, controller states and the command/status bundles of the
// NMEA sentence framer queue.
// ----------------------------------------------------------------------------
package nsfq_pkg;

  localparam int LINE_BUF_DEF    = 64;
  localparam int TEXT_MAX_DEF    = 64;
  localparam int QUEUE_SLOTS_DEF = 8;

  localparam int CHAR_W = 8;
  localparam int DROP_W = 32;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR,
    ST_LF,
    ST_EMPTY,
    ST_RD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic append;
    logic line_clear;
    logic wr_cr;
    logic wr_lf;
    logic drop_inc;
    logic rd_issue;
    logic load_empty;
    logic load_char;
  } cmd_t;

  typedef struct packed {
    logic term;
    logic line_busy;
    logic dollar;
    logic full;
    logic empty;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/nmea_sentence_framer_queue_core.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer_queue_core
// NMEA sentence framer with a ring of sentence slots.
// ----------------------------------------------------------------------------
// Received bytes (tuser 0) build a line that CR or LF closes; a line opening
// with '$' is stored with CR LF, cut to TEXT_MAX-1 characters, in a ring of
// QUEUE_SLOTS slots with one slot kept free, or counted as dropped when the
// ring is full. Characters go straight into the free slot as they arrive,
// and closing a '$' line that fits in the ring writes CR and then LF. A pop
// (tuser 1) emits the oldest sentence, one request per character with tlast
// on the final one; each character is read from the slot memory into a
// register and then loaded into the output register once it is free; a pop
// on an empty ring gives one request with tuser 1.
module nmea_sentence_framer_queue_core #(
  parameter int LINE_BUF    = nsfq_pkg::LINE_BUF_DEF,
  parameter int TEXT_MAX    = nsfq_pkg::TEXT_MAX_DEF,
  parameter int QUEUE_SLOTS = nsfq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] text_char, [39:8] dropped_total
  output logic        m_axis_tlast,   // last_char
  output logic        m_axis_tuser    // [0] queue_empty
);
  import nsfq_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [CHAR_W-1:0] out_char;
  logic [DROP_W-1:0] out_drop;

  nsfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_pop_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nsfq_datapath #(
    .LINE_BUF    (LINE_BUF),
    .TEXT_MAX    (TEXT_MAX),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (m_axis_tuser),
    .out_drop_o  (out_drop)
  );

  assign m_axis_tdata = {out_drop, out_char};

endmodule

// ===== design/nsfq_datapath.sv =====
// ----------------------------------------------------------------------------
// nsfq_datapath
// Line bookkeeping, sentence slot memory, ring pointers, drop counter and
// the output register.
// ----------------------------------------------------------------------------
module nsfq_datapath #(
  parameter int LINE_BUF    = nsfq_pkg::LINE_BUF_DEF,
  parameter int TEXT_MAX    = nsfq_pkg::TEXT_MAX_DEF,
  parameter int QUEUE_SLOTS = nsfq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nsfq_pkg::CHAR_W-1:0]   byte_i,
  input  nsfq_pkg::cmd_t                cmd_i,
  output nsfq_pkg::sts_t                sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [nsfq_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          out_last_o,
  output logic                          out_empty_o,
  output logic [nsfq_pkg::DROP_W-1:0]   out_drop_o
);
  import nsfq_pkg::*;

  localparam int LLW   = $clog2(LINE_BUF);
  localparam int IW    = $clog2(TEXT_MAX);
  localparam int SW    = $clog2(QUEUE_SLOTS);
  localparam int CW    = ((LLW > IW) ? LLW : IW) + 1;
  localparam int DEPTH = QUEUE_SLOTS * (2 ** IW);

  localparam logic [LLW-1:0] LineMaxC = LLW'(LINE_BUF - 1);
  localparam logic [CW-1:0]  LimitC   = CW'(TEXT_MAX - 1);
  localparam logic [SW-1:0]  SlotTopC = SW'(QUEUE_SLOTS - 1);

  logic [CHAR_W:0]     mem_q [DEPTH];
  logic [CHAR_W:0]     rdata_q;
  logic [LLW-1:0]      len_q, len_d;
  logic                dollar_q, dollar_d;
  logic [SW-1:0]       wr_q, wr_d, rd_q, rd_d, wr_next, rd_next;
  logic [IW-1:0]       idx_q, idx_d;
  logic [DROP_W-1:0]   drop_q, drop_d;
  logic                ov_q, ov_d;
  logic [CHAR_W-1:0]   oc_q, oc_d;
  logic                ol_q, ol_d, oe_q, oe_d;
  logic [DROP_W-1:0]   od_q, od_d;
  logic [CW-1:0]       len_x, widx;
  logic                we;
  logic [CHAR_W:0]     wdata;
  logic                out_free;

  assign len_x    = CW'(len_q);
  assign wr_next  = (wr_q == SlotTopC) ? '0 : wr_q + 1'b1;
  assign rd_next  = (rd_q == SlotTopC) ? '0 : rd_q + 1'b1;
  assign out_free = !ov_q || out_ready_i;

  // slot writes: data and CR at the line length, LF one past it
  always_comb begin
    we    = 1'b0;
    widx  = len_x;
    wdata = {1'b0, byte_i};
    if (cmd_i.append) begin
      we    = (len_q != LineMaxC) && (len_x < LimitC);
      wdata = {len_x == LimitC - 1'b1, byte_i};
    end else if (cmd_i.wr_cr) begin
      we    = len_x < LimitC;
      wdata = {len_x == LimitC - 1'b1, CH_CR};
    end else if (cmd_i.wr_lf) begin
      widx  = len_x + 1'b1;
      we    = widx < LimitC;
      wdata = {1'b1, CH_LF};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[{wr_q, widx[IW-1:0]}] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[{rd_q, idx_q}];
    end
  end

  always_comb begin
    len_d    = len_q;
    dollar_d = dollar_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    idx_d    = idx_q;
    drop_d   = drop_q;
    ov_d     = ov_q && !out_ready_i;
    oc_d     = oc_q;
    ol_d     = ol_q;
    oe_d     = oe_q;
    od_d     = od_q;
    if (cmd_i.append) begin
      if (len_q != LineMaxC) begin
        len_d = len_q + 1'b1;
        if (len_q == '0) begin
          dollar_d = byte_i == CH_DOLLAR;
        end
      end else begin
        len_d = '0;
      end
    end
    if (cmd_i.line_clear || cmd_i.wr_lf) begin
      len_d = '0;
    end
    if (cmd_i.wr_lf) begin
      wr_d = wr_next;
    end
    if (cmd_i.drop_inc) begin
      drop_d = drop_q + 1'b1;
    end
    if (cmd_i.load_empty) begin
      ov_d = 1'b1;
      oc_d = '0;
      ol_d = 1'b1;
      oe_d = 1'b1;
      od_d = drop_q;
    end
    if (cmd_i.load_char) begin
      ov_d = 1'b1;
      oc_d = rdata_q[CHAR_W-1:0];
      ol_d = rdata_q[CHAR_W];
      oe_d = 1'b0;
      od_d = drop_q;
      if (rdata_q[CHAR_W]) begin
        idx_d = '0;
        rd_d  = rd_next;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      dollar_q <= 1'b0;
      wr_q     <= '0;
      rd_q     <= '0;
      idx_q    <= '0;
      drop_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      len_q    <= len_d;
      dollar_q <= dollar_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      idx_q    <= idx_d;
      drop_q   <= drop_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oc_q <= oc_d;
    ol_q <= ol_d;
    oe_q <= oe_d;
    od_q <= od_d;
  end

  assign sts_o.term      = (byte_i == CH_CR) || (byte_i == CH_LF);
  assign sts_o.line_busy = len_q != '0;
  assign sts_o.dollar    = dollar_q;
  assign sts_o.full      = wr_next == rd_q;
  assign sts_o.empty     = wr_q == rd_q;
  assign sts_o.rd_last   = rdata_q[CHAR_W];
  assign sts_o.out_free  = out_free;

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;
  assign out_empty_o = oe_q;
  assign out_drop_o  = od_q;

endmodule

// ===== design/nsfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsfq_ctrl
// Sequencer: takes requests, closes lines with CR LF, and walks a slot
// out one character at a time on pop.
// ----------------------------------------------------------------------------
module nsfq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_pop_i,
  output logic           in_ready_o,
  input  nsfq_pkg::sts_t sts_i,
  output nsfq_pkg::cmd_t cmd_o
);
  import nsfq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_pop_i == CMD_POP) begin
            state_d = sts_i.empty ? ST_EMPTY : ST_RD;
          end else if (!sts_i.term) begin
            cmd_o.append = 1'b1;
          end else if (sts_i.line_busy && sts_i.dollar && !sts_i.full) begin
            state_d = ST_CR;
          end else begin
            cmd_o.line_clear = 1'b1;
            cmd_o.drop_inc   = sts_i.line_busy && sts_i.dollar;
          end
        end
      end
      ST_CR: begin
        cmd_o.wr_cr = 1'b1;
        state_d     = ST_LF;
      end
      ST_LF: begin
        cmd_o.wr_lf = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.load_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_char = 1'b1;
          state_d         = sts_i.rd_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/nsfq_checker.sv =====
// ----------------------------------------------------------------------------
// nsfq_checker
// Port-level checks of the framer queue, bound to the top level.
// ----------------------------------------------------------------------------
module nsfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import nsfq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
    else $error("empty marker without tlast or with a character");

  a_plain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_BYTE) &&
    (s_axis_tdata != CH_CR) && (s_axis_tdata != CH_LF) |=> s_axis_tready)
    else $error("plain byte stalled the input");

endmodule

bind nmea_sentence_framer_queue_core nsfq_checker u_nsfq_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for nmea_sentence_framer_queue_core. Bytes and pop commands are
// sent on the input stream. A scoreboard model of the line store, the
// sentence ring and the drop counter predicts each popped character, and
// every output request is checked field by field. Random gaps and stalls
// are applied on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import nsfq_pkg::*;

  localparam int unsigned LINE_BUF    = LINE_BUF_DEF;
  localparam int unsigned TEXT_MAX    = TEXT_MAX_DEF;
  localparam int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF;

  typedef struct packed {
    logic [7:0]  text;
    logic        last;
    logic        empty;
    logic [31:0] drops;
  } char_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned req_cnt = 0;
  int unsigned err_cnt = 0;

  // scoreboard model state
  logic [7:0]  line_m [LINE_BUF];
  int unsigned line_len_m = 0;
  logic [7:0]  slot_m [QUEUE_SLOTS][TEXT_MAX];
  int unsigned slot_len_m [QUEUE_SLOTS];
  int unsigned wr_m = 0;
  int unsigned rd_m = 0;
  logic [31:0] drops_m = '0;

  char_res_t   popped_chars_q [$];

  nmea_sentence_framer_queue_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = rand_byte();
    if (b == CH_CR || b == CH_LF) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // close the current line; '$' lines go to the ring or bump the drop count
  function automatic void close_line();
    int unsigned nxt;
    int unsigned n;
    int unsigned k;
    nxt = (wr_m + 1) % QUEUE_SLOTS;
    if (nxt == rd_m) begin
      drops_m = drops_m + 32'd1;
      return;
    end
    n = line_len_m + 2;
    if (n > TEXT_MAX - 1) n = TEXT_MAX - 1;
    for (k = 0; k < n; k++) begin
      if (k < line_len_m) slot_m[wr_m][k] = line_m[k];
      else if (k == line_len_m) slot_m[wr_m][k] = CH_CR;
      else slot_m[wr_m][k] = CH_LF;
    end
    slot_len_m[wr_m] = n;
    wr_m = nxt;
  endfunction

  function automatic void predict_sentence_chars(input logic cmd, input logic [7:0] b);
    char_res_t r;
    int unsigned k;
    if (cmd == CMD_BYTE) begin
      if (b == CH_LF || b == CH_CR) begin
        if (line_len_m != 0) begin
          if (line_m[0] == CH_DOLLAR) close_line();
          line_len_m = 0;
        end
      end else if (line_len_m < LINE_BUF - 1) begin
        line_m[line_len_m] = b;
        line_len_m++;
      end else begin
        line_len_m = 0;
      end
    end else if (rd_m == wr_m) begin
      r = '{text: 8'h00, last: 1'b1, empty: 1'b1, drops: drops_m};
      popped_chars_q.push_back(r);
    end else begin
      for (k = 0; k < slot_len_m[rd_m]; k++) begin
        r = '{text: slot_m[rd_m][k], last: (k + 1 == slot_len_m[rd_m]), empty: 1'b0,
              drops: drops_m};
        popped_chars_q.push_back(r);
      end
      rd_m = (rd_m + 1) % QUEUE_SLOTS;
    end
  endfunction

  // one request on the input stream; tvalid stays high on return so that a
  // back-to-back request needs no second assignment in the same step
  task automatic send_req(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sentence_chars(cmd, b);
    req_cnt++;
  endtask

  task automatic send_line(input logic [7:0] first, input int unsigned body_len,
                           input logic [7:0] term);
    send_req(CMD_BYTE, first);
    repeat (body_len) send_req(CMD_BYTE, body_byte());
    send_req(CMD_BYTE, term);
  endtask

  task automatic send_pop();
    send_req(CMD_POP, rand_byte());
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      hold_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    char_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (popped_chars_q.size() == 0) begin
        flag_mismatch("output request with nothing expected");
      end else begin
        want = popped_chars_q.pop_front();
        if (m_axis_tdata[7:0] !== want.text)
          flag_mismatch($sformatf("text_char %02h, expected %02h",
                                  m_axis_tdata[7:0], want.text));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("last_char %b, expected %b", m_axis_tlast, want.last));
        if (m_axis_tuser !== want.empty)
          flag_mismatch($sformatf("queue_empty %b, expected %b", m_axis_tuser, want.empty));
        if (m_axis_tdata[39:8] !== want.drops)
          flag_mismatch($sformatf("dropped_total %0d, expected %0d",
                                  m_axis_tdata[39:8], want.drops));
      end
    end
  end

  task automatic test_empty_pop();
    send_pop();
  endtask

  task automatic test_short_sentences();
    send_line(CH_DOLLAR, 0, CH_CR);
    send_line(CH_DOLLAR, 4, CH_LF);
    send_pop();
    send_pop();
    // CR LF pair: the LF closes an empty line
    send_line(CH_DOLLAR, 2, CH_CR);
    send_req(CMD_BYTE, CH_LF);
    send_pop();
  endtask

  task automatic test_ignored_lines();
    send_req(CMD_BYTE, CH_CR);
    send_req(CMD_BYTE, CH_LF);
    send_line(8'h47, 3, CH_CR);
    send_pop();
  endtask

  task automatic test_data_extremes();
    send_req(CMD_BYTE, CH_DOLLAR);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, 8'hFF);
    send_req(CMD_BYTE, 8'h80);
    send_req(CMD_BYTE, 8'h7F);
    send_req(CMD_BYTE, 8'h01);
    send_req(CMD_BYTE, 8'hFE);
    send_req(CMD_BYTE, CH_CR);
    send_req(CMD_POP, 8'hFF);
    send_req(CMD_POP, 8'h00);
  endtask

  task automatic test_long_lines();
    // cut right after CR
    send_line(CH_DOLLAR, TEXT_MAX - 3, CH_CR);
    send_pop();
    // line store overflow, then a line that opens with 8'h51 and is not stored
    send_line(CH_DOLLAR, LINE_BUF - 1, 8'h51);
    send_line(CH_DOLLAR, 1, CH_LF);
    send_pop();
  endtask

  task automatic test_ring_full();
    int unsigned k;
    for (k = 0; k <= QUEUE_SLOTS; k++) send_line(CH_DOLLAR, k % 4, CH_CR);
    repeat (QUEUE_SLOTS) send_pop();
  endtask

  task automatic test_random_traffic();
    int unsigned start_cnt;
    int unsigned pick;
    int unsigned len;
    start_cnt = req_cnt;
    while (req_cnt - start_cnt < 40) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(TEXT_MAX - 6, LINE_BUF)
                                        : $urandom_range(0, 10);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_line(CH_DOLLAR, len, $urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 3) == 0) send_req(CMD_BYTE, CH_LF);
      end else if (pick < 80) begin
        send_pop();
      end else if (pick < 85) begin
        repeat ($urandom_range(QUEUE_SLOTS - 1, QUEUE_SLOTS + 1)) send_pop();
      end else if (pick < 92) begin
        send_line(rand_byte(), len % 8, $urandom_range(0, 1) ? CH_CR : CH_LF);
      end else begin
        repeat ($urandom_range(1, 4)) send_req(CMD_BYTE, rand_byte());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_pop();
    test_short_sentences();
    test_ignored_lines();
    test_data_extremes();
    test_long_lines();
    test_ring_full();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (popped_chars_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && popped_chars_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb_top failed");
    $finish;
  end

endmodule
